### rtl/wpc_pkg.sv
// Shared constants, codes and types for the WAV PCM header checker.
`default_nettype none

package wpc_pkg;

  localparam int unsigned HDR_LEN = 44;
  localparam int unsigned POS_W = 6;

  // Result status codes.
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_BAD_FORMAT = 2'd1;
  localparam logic [1:0] STATUS_NO_AUDIO = 2'd2;

  localparam logic [1:0] BPS_SIXTEEN = 2'd2;
  localparam logic [1:0] BPS_TWENTYFOUR = 2'd3;

  // ceil(2^33 / 3): floor(x * RECIP_THREE / 2^33) == x / 3 for any 32-bit x.
  localparam logic [31:0] RECIP_THREE = 32'hAAAA_AAAB;

  localparam logic [7:0] RIFF_TAG [4] = '{8'h52, 8'h49, 8'h46, 8'h46};

  localparam logic [7:0] FMT_CHUNK [16] = '{
    8'h57, 8'h41, 8'h56, 8'h45, 8'h66, 8'h6D, 8'h74, 8'h20,
    8'h10, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h02, 8'h00
  };

  localparam logic [7:0] TAIL_SIXTEEN [8] = '{
    8'h04, 8'h00, 8'h10, 8'h00, 8'h64, 8'h61, 8'h74, 8'h61
  };

  localparam logic [7:0] TAIL_TWENTYFOUR [8] = '{
    8'h06, 8'h00, 8'h18, 8'h00, 8'h64, 8'h61, 8'h74, 8'h61
  };

  // What the parser hands on once the last header byte is in.
  typedef struct packed {
    logic [31:0] size;
    logic [31:0] rate;
    logic        match_sixteen;
    logic        match_twentyfour;
  } calc_t;

endpackage

`default_nettype wire

### rtl/wpc_ifs.sv
// Valid/ready channel interfaces for header bytes and for results.
`default_nettype none

interface wpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       starts_header;

  modport source (output valid, output header_byte, output starts_header, input ready);
  modport sink (input valid, input header_byte, input starts_header, output ready);
endinterface

interface wpc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  bytes_per_sample;
  logic [31:0] sample_rate;
  logic [29:0] sample_frames;

  modport source (output valid, output status, output bytes_per_sample,
                  output sample_rate, output sample_frames, input ready);
  modport sink (input valid, input status, input bytes_per_sample,
                input sample_rate, input sample_frames, output ready);
endinterface

`default_nettype wire

### rtl/wpc_parser.sv
// Byte parser: input register, position tracking, pattern matching and field capture.
`default_nettype none

module wpc_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  wpc_in_if.sink             hdr,
  output wpc_pkg::calc_t     calc,
  output logic               calc_valid,
  input  wire logic          calc_ready
);

  logic                        in_valid;
  logic [7:0]                  in_byte;
  logic                        in_start;

  logic [wpc_pkg::POS_W-1:0]   byte_position;
  logic                        match_sixteen;
  logic                        match_twentyfour;
  logic [31:0]                 rate_capture;
  logic [31:0]                 size_capture;

  logic [wpc_pkg::POS_W-1:0]   pos_eff;
  logic [wpc_pkg::POS_W-1:0]   byte_position_next;
  logic                        match_sixteen_next;
  logic                        match_twentyfour_next;
  logic [31:0]                 rate_capture_next;
  logic [31:0]                 size_capture_next;
  logic                        is_final;
  logic                        calc_free;
  logic                        consume;

  // A start flag puts the state back to its reset values before the byte is used.
  always_comb begin
    pos_eff               = in_start ? '0 : byte_position;
    match_sixteen_next    = in_start | match_sixteen;
    match_twentyfour_next = in_start | match_twentyfour;
    rate_capture_next     = in_start ? '0 : rate_capture;
    size_capture_next     = in_start ? '0 : size_capture;

    if (pos_eff < wpc_pkg::POS_W'(4)) begin
      if (in_byte != wpc_pkg::RIFF_TAG[pos_eff[1:0]]) begin
        match_sixteen_next    = 1'b0;
        match_twentyfour_next = 1'b0;
      end
    end else if (pos_eff >= wpc_pkg::POS_W'(8) && pos_eff < wpc_pkg::POS_W'(24)) begin
      if (in_byte != wpc_pkg::FMT_CHUNK[4'(pos_eff - wpc_pkg::POS_W'(8))]) begin
        match_sixteen_next    = 1'b0;
        match_twentyfour_next = 1'b0;
      end
    end else if (pos_eff >= wpc_pkg::POS_W'(24) && pos_eff < wpc_pkg::POS_W'(28)) begin
      rate_capture_next[{pos_eff[1:0], 3'b000} +: 8] = in_byte;
    end else if (pos_eff >= wpc_pkg::POS_W'(32) && pos_eff < wpc_pkg::POS_W'(40)) begin
      if (in_byte != wpc_pkg::TAIL_SIXTEEN[pos_eff[2:0]]) begin
        match_sixteen_next = 1'b0;
      end
      if (in_byte != wpc_pkg::TAIL_TWENTYFOUR[pos_eff[2:0]]) begin
        match_twentyfour_next = 1'b0;
      end
    end else if (pos_eff >= wpc_pkg::POS_W'(40) &&
                 pos_eff < wpc_pkg::POS_W'(wpc_pkg::HDR_LEN)) begin
      size_capture_next[{pos_eff[1:0], 3'b000} +: 8] = in_byte;
    end

    // The position stops at the header length until the next start flag.
    if (pos_eff < wpc_pkg::POS_W'(wpc_pkg::HDR_LEN)) begin
      byte_position_next = pos_eff + wpc_pkg::POS_W'(1);
    end else begin
      byte_position_next = pos_eff;
    end

    is_final  = (pos_eff == wpc_pkg::POS_W'(wpc_pkg::HDR_LEN - 1));
    calc_free = !calc_valid || calc_ready;
    consume   = in_valid && (!is_final || calc_free);
  end

  assign hdr.ready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      byte_position    <= '0;
      match_sixteen    <= 1'b1;
      match_twentyfour <= 1'b1;
      rate_capture     <= '0;
      size_capture     <= '0;
      calc_valid       <= 1'b0;
    end else begin
      if (hdr.ready) begin
        in_valid <= hdr.valid;
      end
      if (consume) begin
        byte_position    <= byte_position_next;
        match_sixteen    <= match_sixteen_next;
        match_twentyfour <= match_twentyfour_next;
        rate_capture     <= rate_capture_next;
        size_capture     <= size_capture_next;
      end
      calc_valid <= (calc_valid && !calc_ready) || (consume && is_final);
    end
  end

  always_ff @(posedge clk) begin
    if (hdr.valid && hdr.ready) begin
      in_byte  <= hdr.header_byte;
      in_start <= hdr.starts_header;
    end
    if (consume && is_final) begin
      calc.size             <= size_capture_next;
      calc.rate             <= rate_capture_next;
      calc.match_sixteen    <= match_sixteen_next;
      calc.match_twentyfour <= match_twentyfour_next;
    end
  end

endmodule

`default_nettype wire

### rtl/wpc_frames.sv
// Frame count stage: divide by 4 or 6, pick the status, hold the result register.
`default_nettype none

module wpc_frames (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire wpc_pkg::calc_t calc,
  input  wire logic          calc_valid,
  output logic               calc_ready,
  wpc_out_if.source          res
);

  logic        prod_valid;
  logic        prod_m16;
  logic        prod_m24;
  logic [31:0] prod_rate;
  logic [29:0] prod_q4;
  logic [29:0] prod_q6;

  logic        out_valid;
  logic [1:0]  out_status;
  logic [1:0]  out_bps;
  logic [31:0] out_rate;
  logic [29:0] out_frames;

  logic [62:0] product;
  logic        out_free;
  logic [1:0]  status_sel;
  logic [1:0]  bps_sel;
  logic [31:0] rate_sel;
  logic [29:0] frames_sel;

  // size / 6 == (size / 2) / 3, the division by three done by reciprocal.
  assign product    = calc.size[31:1] * wpc_pkg::RECIP_THREE;
  assign out_free   = !out_valid || res.ready;
  assign calc_ready = !prod_valid || out_free;

  always_comb begin
    if (!prod_m16 && !prod_m24) begin
      status_sel = wpc_pkg::STATUS_BAD_FORMAT;
      bps_sel    = wpc_pkg::BPS_SIXTEEN;
      rate_sel   = '0;
      frames_sel = '0;
    end else begin
      bps_sel    = prod_m16 ? wpc_pkg::BPS_SIXTEEN : wpc_pkg::BPS_TWENTYFOUR;
      rate_sel   = prod_rate;
      frames_sel = prod_m16 ? prod_q4 : prod_q6;
      status_sel = (frames_sel == '0) ? wpc_pkg::STATUS_NO_AUDIO : wpc_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (calc_ready) begin
        prod_valid <= calc_valid;
      end
      if (out_free) begin
        out_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (calc_valid && calc_ready) begin
      prod_m16  <= calc.match_sixteen;
      prod_m24  <= calc.match_twentyfour;
      prod_rate <= calc.rate;
      prod_q4   <= calc.size[31:2];
      prod_q6   <= product[62:33];
    end
    if (prod_valid && out_free) begin
      out_status <= status_sel;
      out_bps    <= bps_sel;
      out_rate   <= rate_sel;
      out_frames <= frames_sel;
    end
  end

  assign res.valid            = out_valid;
  assign res.status           = out_status;
  assign res.bytes_per_sample = out_bps;
  assign res.sample_rate      = out_rate;
  assign res.sample_frames    = out_frames;

endmodule

`default_nettype wire

### rtl/wav_pcm_header_checker.sv
// Top level of the canonical WAV PCM stereo header checker.
`default_nettype none

// The checker takes a canonical 44-byte WAV header one byte per transfer on
// hdr, in file order, and gives one result transfer on res after the last
// byte (byte 43). A byte with starts_header set is always taken as byte 0 of
// a new header. Bytes 0-3 must read RIFF, bytes 8-23 must hold the PCM stereo
// fmt chunk, and bytes 32-39 must match either the 16-bit or the legacy 24-bit
// block-align/bits/data pattern; otherwise the status is "bad format" with a
// zero rate and frame count. The sample rate (bytes 24-27) and the data size
// (bytes 40-43) are read little-endian, and the frame count is the data size
// over 4 (16-bit) or 6 (24-bit); a zero frame count gives "no audio". Bytes
// after byte 43 are swallowed silently until the next start flag.
// Throughput is one byte per clock cycle while the result path is not backed
// up. The result for a header passes through the byte register and parser,
// the capture register, the reciprocal multiplier that divides by three and
// its product register, and then the result register.
// Three finished results can wait inside without holding up the byte stream,
// so a sink that stalls only briefly never slows the input.

module wav_pcm_header_checker (
  input wire logic  clk,
  input wire logic  rst,
  wpc_in_if.sink    hdr,
  wpc_out_if.source res
);

  wpc_pkg::calc_t calc;
  logic           calc_valid;
  logic           calc_ready;

  // Position tracking, compares and capture of rate and size.
  wpc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .hdr        (hdr),
    .calc       (calc),
    .calc_valid (calc_valid),
    .calc_ready (calc_ready)
  );

  // Division, status selection and the result register.
  wpc_frames u_frames (
    .clk        (clk),
    .rst        (rst),
    .calc       (calc),
    .calc_valid (calc_valid),
    .calc_ready (calc_ready),
    .res        (res)
  );

  // A rejected header reports nothing but the fixed defaults.
  a_bad_format_clean : assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == wpc_pkg::STATUS_BAD_FORMAT) |->
      (res.sample_rate == '0 && res.sample_frames == '0 &&
       res.bytes_per_sample == wpc_pkg::BPS_SIXTEEN))
    else $error("bad-format result carries nonzero fields");

  // A good header always has audio; no audio always means zero frames.
  a_ok_has_frames : assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.status == wpc_pkg::STATUS_OK ||
                   res.status == wpc_pkg::STATUS_NO_AUDIO)) |->
      ((res.status == wpc_pkg::STATUS_OK) == (res.sample_frames != '0)))
    else $error("status disagrees with frame count");

  // A 24-bit header can never yield more than a sixth of the 32-bit range.
  a_frames_range : assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.bytes_per_sample == wpc_pkg::BPS_TWENTYFOUR) |->
      (res.sample_frames <= 30'd715827882))
    else $error("24-bit frame count out of range");

  // The capture register holds its contents while the next stage is stalled.
  a_calc_holds : assert property (@(posedge clk) disable iff (rst)
    (calc_valid && !calc_ready) |=> (calc_valid && $stable(calc)))
    else $error("capture register changed while stalled");

endmodule

`default_nettype wire
